>>> src/bu3_pkg.sv
// Shared types, constants and helpers for the 3x bilinear upscaler.
// No dependencies; imported by every module of the block but the RAM.
package bu3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 11;               // config register width
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COORD_W = 12;
  localparam int PHASE_W = 2;                // interpolation phase 1..3

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;            // value, out_row, out_col
  localparam int USER_W     = 1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

  // Weighted sum of two bytes with weights summing to 3 fits in 10 bits.
  localparam int SUM_W   = 10;
  // floor(x/3) == (x*683)>>11 for every x < 2048.
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;
  localparam int PROD_W   = SUM_W + 10;

  localparam logic [PHASE_W-1:0] PHASE_FIRST = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 2'd3;

  typedef struct packed {
    logic [PHASE_W-1:0] k;   // weight of b
    logic [PIX_W-1:0]   a;
    logic [PIX_W-1:0]   b;
  } lerp_req_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_MIN) r = SIZE_MIN;
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

>>> src/bu3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bu3_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bu3_lerp.sv
// Shared interpolation unit: ((3-k)*a + k*b)/3, truncated.
// Depends on bu3_pkg.
module bu3_lerp (
  input  bu3_pkg::lerp_req_t          req,
  output logic [bu3_pkg::PIX_W-1:0]   q
);
  import bu3_pkg::*;

  logic [PHASE_W-1:0] kc;
  logic [SUM_W-1:0]   sum;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    kc   = PHASE_LAST - req.k;
    // a zero weight on a drops that operand entirely: in the top row the line buffer
    // word may never have been written
    sum  = ((kc == '0) ? SUM_W'(0) : SUM_W'(kc) * SUM_W'(req.a)) +
           SUM_W'(req.k) * SUM_W'(req.b);
    // divide by 3 through the reciprocal
    prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
    q    = PIX_W'(prod >> DIV3_SH);
  end

endmodule

>>> src/bilinear_upscale_by_three_core.sv
// 3x bilinear upscaler: one input pixel in, its output tile (up to 3x3) out.
// A pixel word passes the read state, both column passes and the row pass before the
// first word of its tile is registered; no new pixel is taken until the tile is out.
// Each tile row costs two column passes plus one pass per word; output stalls hold it.
// Reset (rst, synchronous): counters, edge pixels and handshakes cleared,
// size registers set to 4x4; the line buffer is not cleared.
module bilinear_upscale_by_three_core (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bu3_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] pixel
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bu3_pkg::OUT_DATA_W-1:0]    m_tdata,   // [7:0] value, [19:8] out_row,
                                                       // [31:20] out_col
  output logic                              m_tlast,   // tile_last
  output logic [bu3_pkg::USER_W-1:0]        m_tuser,   // [0] frame_done
  // configuration
  input  logic                              cfg_we,
  input  logic [bu3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bu3_pkg::SIZE_W-1:0]        cfg_data
);
  import bu3_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,  // waiting for a pixel word
    ST_READ = 5'b00010,  // line buffer read data arriving, write back current pixel
    ST_VL   = 5'b00100,  // column pass, left side
    ST_VR   = 5'b01000,  // column pass, right side
    ST_EMIT = 5'b10000   // row pass, one output word per step
  } state_t;

  state_t state, state_next;

  // configuration
  logic [SIZE_W-1:0] width_reg, height_reg;
  logic [SIZE_W-1:0] w_eff, h_eff;

  // position of the next pixel
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] c_wrap;
  logic [ROW_W-1:0] r_wrap;
  logic [SIZE_W-1:0] c_inc, r_inc;
  logic col_last, row_last;

  // neighbors kept across pixels
  logic [PIX_W-1:0] left_pixel, upper_left_pixel;

  // working set of the current pixel
  logic [PIX_W-1:0] cur, above, vl, vr;
  logic [COL_W-1:0] c_cur;
  logic [ROW_W-1:0] r_cur;
  logic             frame_end;
  logic [PHASE_W-1:0] k, n;

  logic [PIX_W-1:0] ram_rdata;
  logic             accept, out_free;

  lerp_req_t        req;
  logic [PIX_W-1:0] lerp_q;

  logic [COORD_W-1:0] row3, col3, out_row, out_col;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // effective size and wrap of a counter left beyond a shrunken size
  always_comb begin
    w_eff    = clamp_size(width_reg, SIZE_W'(MAX_WIDTH));
    h_eff    = clamp_size(height_reg, SIZE_W'(MAX_HEIGHT));
    c_wrap   = (SIZE_W'(col_count) >= w_eff) ? '0 : col_count;
    r_wrap   = (SIZE_W'(row_count) >= h_eff) ? '0 : row_count;
    c_inc    = SIZE_W'(c_wrap) + SIZE_W'(1);
    r_inc    = SIZE_W'(r_wrap) + SIZE_W'(1);
    col_last = (c_inc >= w_eff);
    row_last = (r_inc >= h_eff);
  end

  // previous row; read at accept, written back with the new pixel in the read state
  bu3_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_line (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (c_cur),
    .wdata (cur),
    .raddr (c_wrap),
    .rdata (ram_rdata)
  );

  // operand select for the shared unit
  always_comb begin
    case (state)
      ST_VL:   req = '{k: k, a: upper_left_pixel, b: left_pixel};
      ST_VR:   req = '{k: k, a: above, b: cur};
      default: req = '{k: n, a: vl, b: vr};
    endcase
  end

  bu3_lerp u_lerp (
    .req (req),
    .q   (lerp_q)
  );

  // output coordinates: 3r+k-3, 3c+n-3 (top row / left column only use phase 3)
  always_comb begin
    row3    = COORD_W'(r_cur) + COORD_W'({r_cur, 1'b0});
    col3    = COORD_W'(c_cur) + COORD_W'({c_cur, 1'b0});
    out_row = row3 + COORD_W'(k) - COORD_W'(3);
    out_col = col3 + COORD_W'(n) - COORD_W'(3);
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_READ;
      ST_READ: state_next = ST_VL;
      ST_VL:   state_next = ST_VR;
      ST_VR:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free && n == PHASE_LAST) begin
          state_next = (k == PHASE_LAST) ? ST_IDLE : ST_VL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      width_reg        <= SIZE_RESET;
      height_reg       <= SIZE_RESET;
      col_count        <= '0;
      row_count        <= '0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_reg  <= cfg_data;
          REG_HEIGHT: height_reg <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        if (col_last) begin
          col_count <= '0;
          row_count <= row_last ? '0 : ROW_W'(r_inc);
        end else begin
          col_count <= COL_W'(c_inc);
          row_count <= r_wrap;
        end
      end

      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
        // tile done: current pixel becomes the left neighbor
        if (n == PHASE_LAST && k == PHASE_LAST) begin
          left_pixel       <= cur;
          upper_left_pixel <= above;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      cur       <= s_tdata[PIX_W-1:0];
      c_cur     <= c_wrap;
      r_cur     <= r_wrap;
      frame_end <= col_last && row_last;
    end
    case (state)
      ST_READ: begin
        above <= ram_rdata;
        k     <= (r_cur == '0) ? PHASE_LAST : PHASE_FIRST;
      end
      ST_VL: vl <= lerp_q;
      ST_VR: begin
        vr <= lerp_q;
        n  <= (c_cur == '0) ? PHASE_LAST : PHASE_FIRST;
      end
      ST_EMIT: begin
        if (out_free) begin
          m_tdata <= {out_col, out_row, lerp_q};
          m_tlast <= (n == PHASE_LAST) && (k == PHASE_LAST);
          m_tuser <= USER_W'((n == PHASE_LAST) && (k == PHASE_LAST) && frame_end);
          if (n == PHASE_LAST) begin
            k <= k + PHASE_W'(1);
          end else begin
            n <= n + PHASE_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/bu3_checker.sv
// Port-level checks for the 3x upscaler, bound to the top level.
// Depends on bu3_pkg and bilinear_upscale_by_three_core.
module bu3_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bu3_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast,
  input logic [bu3_pkg::USER_W-1:0]     m_tuser
);
  import bu3_pkg::*;

  // one pixel at a time: input closes right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still open after pixel word");

  // a pending mid-tile word means the tile is not finished
  a_tile_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("input open inside a tile");

  // end of frame only on the end of a tile
  a_frame_on_tile_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("frame_done without tile_last");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output word changed under stall");

endmodule

bind bilinear_upscale_by_three_core bu3_checker u_bu3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

>>> dv/tb_bilinear_upscale_by_three_core.sv
// Testbench for bilinear_upscale_by_three_core. Streams whole frames of pixels of many
// sizes, predicts every output tile word and checks the words in arrival order.
// Depends on bu3_pkg and the core RTL only.
module tb_bilinear_upscale_by_three_core;
  import bu3_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RAND_PIXELS  = 140;
  localparam int HOLD_CYCLES  = 400;        // long output back-pressure window
  localparam int DRAIN_CYCLES = 40;         // settle time after the last word
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int MAX_PRINTS   = 100;
  localparam int DIR_ROWS     = 21;

  // Directed table rows: either one pixel word, or a size change at a frame boundary.
  typedef enum logic {ROW_PIXEL, ROW_SIZE} dir_kind_t;

  typedef struct packed {
    dir_kind_t          kind;
    logic [SIZE_W-1:0]  arg0;     // pixel value, or width
    logic [SIZE_W-1:0]  arg1;     // height
    logic               typed;    // corner value below is spelled out
    logic [PIX_W-1:0]   corner;
  } dir_row_t;

  typedef struct packed {
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               tile_last;
    logic               frame_done;
  } tile_word_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;     // [7:0] pixel
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;            // [7:0] value, [19:8] out_row, [31:20] out_col
  logic                  m_tlast;            // tile_last
  logic [USER_W-1:0]     m_tuser;            // [0] frame_done
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WIDTH;
  logic [SIZE_W-1:0]     cfg_data  = '0;

  bilinear_upscale_by_three_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Predictor state: a shadow of the block's line buffer, edge pixels, position and sizes.
  logic [PIX_W-1:0]  line_buf [MAX_WIDTH];
  logic [PIX_W-1:0]  left_px    = '0;
  logic [PIX_W-1:0]  up_left_px = '0;
  logic [ROW_W-1:0]  row_pos    = '0;
  logic [COL_W-1:0]  col_pos    = '0;
  logic [SIZE_W-1:0] img_w      = SIZE_W'(4);
  logic [SIZE_W-1:0] img_h      = SIZE_W'(4);

  tile_word_t tile_q [$];      // output words still owed by the block, oldest first

  // Idling controls set by the stimulus sequencer and read by the sender and the receiver.
  bit steady_send = 1'b0;
  bit steady_recv = 1'b0;
  bit hold_req    = 1'b0;

  int err_count   = 0;
  int words_seen  = 0;
  int pixels_sent = 0;
  int frames_done = 0;
  int holds_done  = 0;

  dir_row_t dir_tab [DIR_ROWS];

  // Sizes outside 2..max behave as the nearest legal size.
  function automatic int eff_size(input logic [SIZE_W-1:0] v, input int top);
    if (v < 2) return 2;
    if (v > top) return top;
    return int'(v);
  endfunction

  // One interpolation step at phase k of 1..3 between a and b, truncated.
  function automatic int blend3(input int k, input int a, input int b);
    return ((3 - k) * a + k * b) / 3;
  endfunction

  // corner < 0: the tile is checked against the predictor only.
  function automatic dir_row_t px_row(input int px, input int corner);
    dir_row_t r;
    r.kind   = ROW_PIXEL;
    r.arg0   = SIZE_W'(px);
    r.arg1   = '0;
    r.typed  = (corner >= 0);
    r.corner = PIX_W'(corner);
    return r;
  endfunction

  function automatic dir_row_t size_row(input int w, input int h);
    dir_row_t r;
    r.kind   = ROW_SIZE;
    r.arg0   = SIZE_W'(w);
    r.arg1   = SIZE_W'(h);
    r.typed  = 1'b0;
    r.corner = '0;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic string word_str(input tile_word_t t);
    return $sformatf("val %0d row %0d col %0d last %0b done %0b",
                     t.value, t.row, t.col, t.tile_last, t.frame_done);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Work out the tile that one accepted pixel produces and queue it.
  // Tile covers output rows 3r-2..3r and cols 3c-2..3c, clipped at the top/left edge,
  // emitted row by row; columns get the vertical pass first, then the horizontal one.
  task automatic predict_tile(input logic [PIX_W-1:0] px, input bit typed,
                              input logic [PIX_W-1:0] corner);
    int w, h, r, c, k, n, above, vl, vr;
    bit frame_end;
    tile_word_t wd;
    w = eff_size(img_w, MAX_WIDTH);
    h = eff_size(img_h, MAX_HEIGHT);
    if (col_pos >= w) col_pos = '0;
    if (row_pos >= h) row_pos = '0;
    r = row_pos;
    c = col_pos;
    above = line_buf[c];
    frame_end = (r == h - 1) && (c == w - 1);
    for (k = (r > 0) ? 1 : 3; k <= 3; k++) begin
      vl = blend3(k, up_left_px, left_px);
      vr = blend3(k, above, px);
      for (n = (c > 0) ? 1 : 3; n <= 3; n++) begin
        wd.value      = PIX_W'(blend3(n, vl, vr));
        wd.row        = COORD_W'(3 * r + k - 3);
        wd.col        = COORD_W'(3 * c + n - 3);
        wd.tile_last  = (k == 3) && (n == 3);
        wd.frame_done = wd.tile_last && frame_end;
        if (typed && wd.tile_last) wd.value = corner;
        tile_q.push_back(wd);
      end
    end
    up_left_px  = PIX_W'(above);
    line_buf[c] = px;
    left_px     = px;
    if (c + 1 >= w) begin
      col_pos = '0;
      row_pos = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
    end else begin
      col_pos = COL_W'(c + 1);
    end
    if (frame_end) frames_done++;
  endtask

  // Offer one pixel word after a random gap; predict its tile once it is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                            input logic [PIX_W-1:0] corner);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_tile(px, typed, corner);
    pixels_sent++;
  endtask

  // Stop offering and wait until every owed word has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (tile_q.size() != 0) @(posedge clk);
  endtask

  // Both size registers, back to back; only called with the block drained.
  task automatic write_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    img_w = w;
    img_h = h;
  endtask

  // A whole frame of random pixels at a new size. Frames always complete, so below the top
  // row (read with zero weight) the line buffer is only read where this frame wrote it.
  task automatic run_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    int npix;
    wait_drained();
    write_size(w, h);
    npix = eff_size(w, MAX_WIDTH) * eff_size(h, MAX_HEIGHT);
    repeat (npix) send_pixel(rand_pixel(), 1'b0, '0);
  endtask

  task automatic check_word();
    tile_word_t got, want;
    got.value      = m_tdata[7:0];
    got.row        = m_tdata[19:8];
    got.col        = m_tdata[31:20];
    got.tile_last  = m_tlast;
    got.frame_done = m_tuser[0];
    words_seen++;
    if (tile_q.size() == 0) begin
      report_mismatch({"word with nothing owed: ", word_str(got)});
    end else begin
      want = tile_q.pop_front();
      if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
          got.tile_last !== want.tile_last || got.frame_done !== want.frame_done) begin
        report_mismatch({"got ", word_str(got), " | want ", word_str(want)});
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) check_word();
  end

  // Receiver: random stall before each word, plus one long hold-off on request.
  initial begin : out_side
    int stall;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      stall = steady_recv ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  // Main sequence: directed table, long strips, then random frames.
  initial begin : in_side
    int i, fr, rand_count;
    logic [SIZE_W-1:0] w, h;
    // A tile's corner word is the input pixel itself, so typed corners need no math.
    dir_tab = '{
      // reset size 4x4: extremes, first pixel (single word), top row, left column
      px_row(0, 0),   px_row(255, 255), px_row(0, -1),   px_row(255, -1),
      px_row(255, -1), px_row(0, -1),   px_row(255, 255), px_row(0, -1),
      px_row(1, -1),   px_row(254, -1), px_row(128, -1),  px_row(127, -1),
      px_row(0, -1),   px_row(255, -1), px_row(2, -1),    px_row(255, 255),
      // sizes below the minimum act as 2x2
      size_row(0, 1),
      px_row(255, 255), px_row(0, -1), px_row(0, -1), px_row(255, 255)
    };
    rand_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_SIZE) begin
        wait_drained();
        write_size(dir_tab[i].arg0, dir_tab[i].arg1);
      end else begin
        send_pixel(dir_tab[i].arg0[PIX_W-1:0], dir_tab[i].typed, dir_tab[i].corner);
      end
    end

    // A wide two-row strip, then a tall two-column one.
    run_frame(SIZE_W'(40), SIZE_W'(2));
    run_frame(SIZE_W'(2), SIZE_W'(40));

    // Random small frames; idling style varies per frame.
    fr = 0;
    while (rand_count < RAND_PIXELS) begin
      steady_send = ($urandom_range(0, 3) == 0);
      steady_recv = ($urandom_range(0, 3) == 0);
      if (fr == 3) begin
        // output held off while input keeps coming: block fills and stalls its input
        w = SIZE_W'(6);
        h = SIZE_W'(5);
        steady_send = 1'b1;
        hold_req    = 1'b1;
      end else begin
        w = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 1))
                                        : SIZE_W'($urandom_range(2, 8));
        h = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 1))
                                        : SIZE_W'($urandom_range(2, 6));
      end
      run_frame(w, h);
      rand_count += eff_size(w, MAX_WIDTH) * eff_size(h, MAX_HEIGHT);
      fr++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d pixels in %0d frames, %0d output words checked, %0d mismatches",
             pixels_sent, frames_done, words_seen, err_count);
    $display("sizes from clamped 2x2 up to 40-pixel strips, %0d long output hold-off",
             holds_done);
    if (err_count == 0 && tile_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("timeout: %0d words still owed", tile_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

>>> bilinear_upscale_by_three_core.f
src/bu3_pkg.sv
src/bu3_ram.sv
src/bu3_lerp.sv
src/bilinear_upscale_by_three_core.sv
src/bu3_checker.sv
dv/tb_bilinear_upscale_by_three_core.sv
